// File: design/spfd_pkg.sv
// ----------------------------------------------------------------------------
// Soil probe frame decoder package
// Shared types, register codes, frame constants and the CRC-8 byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spfd_pkg;

   // Frame layout.
   localparam logic [3:0] FRAME_LAST = 4'd8;
   localparam logic [3:0] NO_FRAME   = 4'd9;

   // Frame content codes.
   localparam logic [7:0]         FAMILY_CODE       = 8'h34;
   localparam logic [7:0]         CRC_POLY          = 8'h31;
   localparam logic [3:0]         SUBTYPE_NO_OFFSET = 4'h4;
   localparam logic signed [12:0] OFFSET_TENTHS     = 13'sd400;

   // Register port geometry.
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 13;

   // Register reset values.
   localparam logic [7:0]         CRC_INIT_RESET    = 8'd0;
   localparam logic [11:0]        LOW_BATTERY_RESET = 12'd1200;
   localparam logic signed [12:0] MIN_TEMP_RESET    = -13'sd500;
   localparam logic signed [12:0] MAX_TEMP_RESET    = 13'sd850;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CRC_INIT       = 2'd0,
      CSR_LOW_BATTERY_MV = 2'd1,
      CSR_MIN_TEMP       = 2'd2,
      CSR_MAX_TEMP       = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK     = 3'd0,
      STATUS_FAMILY = 3'd1,
      STATUS_CRC    = 3'd2,
      STATUS_SUM    = 3'd3,
      STATUS_RANGE  = 3'd4
   } status_type;

   // Configuration register contents.
   typedef struct packed {
      logic [7:0]  crc_init;
      logic [11:0] low_battery_mv;
      logic [12:0] min_temp_tenths;
      logic [12:0] max_temp_tenths;
   } cfg_type;

   // Everything captured from one complete frame.
   typedef struct packed {
      logic        family_ok;
      logic        crc_ok;
      logic        sum_ok;
      logic [23:0] sensor_id;
      logic [7:0]  temp_hi_byte;
      logic [7:0]  temp_lo_byte;
      logic [7:0]  battery_byte;
      logic [7:0]  rssi_dbm;
   } close_type;

   // CRC-8, MSB first, one byte per call.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: design/spfd_if.sv
// ----------------------------------------------------------------------------
// Soil probe frame decoder channels
// Valid/ready channels for frame bytes in and decoded results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spfd_req_if;
   logic              valid;
   logic              ready;
   logic [7:0]        frame_byte;
   logic              start_of_frame;
   logic signed [7:0] signal_dbm;

   modport source (output valid, frame_byte, start_of_frame, signal_dbm, input ready);
   modport sink   (input valid, frame_byte, start_of_frame, signal_dbm, output ready);
endinterface

interface spfd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [23:0]        sensor_id;
   logic signed [12:0] temp_tenths;
   logic [11:0]        battery_mv;
   logic               battery_low;
   logic signed [7:0]  rssi_dbm;

   modport source (output valid, status, sensor_id, temp_tenths, battery_mv, battery_low,
                   rssi_dbm, input ready);
   modport sink   (input valid, status, sensor_id, temp_tenths, battery_mv, battery_low,
                   rssi_dbm, output ready);
endinterface

`default_nettype wire

// File: design/spfd_csr.sv
// ----------------------------------------------------------------------------
// Soil probe frame decoder registers
// Write-only configuration registers behind a plain indexed write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfd_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [spfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [spfd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output spfd_pkg::cfg_type                         cfg
);
   import spfd_pkg::*;

   cfg_type cfg_ff;

   // Register writes; each register keeps only its own width.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_init        <= CRC_INIT_RESET;
         cfg_ff.low_battery_mv  <= LOW_BATTERY_RESET;
         cfg_ff.min_temp_tenths <= MIN_TEMP_RESET;
         cfg_ff.max_temp_tenths <= MAX_TEMP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_CRC_INIT:       cfg_ff.crc_init        <= csr_write_data[7:0];
            CSR_LOW_BATTERY_MV: cfg_ff.low_battery_mv  <= csr_write_data[11:0];
            CSR_MIN_TEMP:       cfg_ff.min_temp_tenths <= csr_write_data[12:0];
            CSR_MAX_TEMP:       cfg_ff.max_temp_tenths <= csr_write_data[12:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: design/spfd_frame.sv
// ----------------------------------------------------------------------------
// Soil probe frame tracker
// Follows the byte position, runs CRC and sum, captures fields, and hands a
// complete frame record to the decode stage on byte 8.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfd_frame (
   input  wire logic           clock,
   input  wire logic           reset,
   spfd_req_if.sink            req,
   input  wire logic [7:0]     crc_init,
   output logic                close_valid,
   output spfd_pkg::close_type close,
   input  wire logic           close_ready
);
   import spfd_pkg::*;

   logic [3:0]  idx_ff, idx_in;
   logic [7:0]  crc_ff;
   logic [7:0]  sum_ff;
   logic        family_ff;
   logic [23:0] id_ff;
   logic [7:0]  temp_hi_ff;
   logic [7:0]  temp_lo_ff;
   logic [7:0]  battery_ff;
   logic [7:0]  rssi_ff;
   logic        close_valid_ff, close_valid_in;
   close_type   close_ff;

   logic       accept;
   logic [3:0] idx_cur;
   logic [7:0] crc_cur;
   logic [7:0] sum_cur;
   logic [7:0] rssi_cur;
   logic       closing;

   // A new byte is taken whenever the record register is free or draining.
   assign req.ready = !close_valid_ff || close_ready;
   assign accept    = req.valid && req.ready;

   // A start mark restarts the frame before this byte is processed.
   always_comb begin
      idx_cur  = req.start_of_frame ? 4'd0 : idx_ff;
      crc_cur  = req.start_of_frame ? crc_init : crc_ff;
      sum_cur  = req.start_of_frame ? 8'd0 : sum_ff;
      rssi_cur = req.start_of_frame ? req.signal_dbm : rssi_ff;
      closing  = (idx_cur == FRAME_LAST);
   end

   // Next byte position and record hand-off.
   always_comb begin
      idx_in = idx_ff;
      if (accept) begin
         if (idx_cur < FRAME_LAST) begin
            idx_in = 4'(idx_cur + 4'd1);
         end else begin
            idx_in = NO_FRAME;
         end
      end
      if (accept && closing) begin
         close_valid_in = 1'b1;
      end else if (close_ready) begin
         close_valid_in = 1'b0;
      end else begin
         close_valid_in = close_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= NO_FRAME;
         close_valid_ff <= 1'b0;
      end else begin
         idx_ff         <= idx_in;
         close_valid_ff <= close_valid_in;
      end
   end

   // Running checks and captured bytes of the open frame.
   always_ff @(posedge clock) begin
      if (accept && (idx_cur < FRAME_LAST)) begin
         crc_ff  <= crc8_update(crc_cur, req.frame_byte);
         sum_ff  <= 8'(sum_cur + req.frame_byte);
         rssi_ff <= rssi_cur;
         unique case (idx_cur)
            4'd0:    family_ff   <= (req.frame_byte == FAMILY_CODE);
            4'd1:    id_ff[23:16] <= req.frame_byte;
            4'd2:    id_ff[15:8]  <= req.frame_byte;
            4'd3:    id_ff[7:0]   <= req.frame_byte;
            4'd4:    temp_hi_ff  <= req.frame_byte;
            4'd5:    temp_lo_ff  <= req.frame_byte;
            4'd6:    battery_ff  <= req.frame_byte;
            default: ;
         endcase
      end
   end

   // The frame record; byte 8 is the expected sum.
   always_ff @(posedge clock) begin
      if (accept && closing) begin
         close_ff.family_ok    <= family_ff;
         close_ff.crc_ok       <= (crc_ff == 8'd0);
         close_ff.sum_ok       <= (sum_ff == req.frame_byte);
         close_ff.sensor_id    <= id_ff;
         close_ff.temp_hi_byte <= temp_hi_ff;
         close_ff.temp_lo_byte <= temp_lo_ff;
         close_ff.battery_byte <= battery_ff;
         close_ff.rssi_dbm     <= rssi_ff;
      end
   end

   assign close_valid = close_valid_ff;
   assign close       = close_ff;

   // The byte position never leaves the range of a frame plus the idle code.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= NO_FRAME)
      else $error("byte position out of range");

   // A start-marked byte is byte 0, so the next byte is byte 1.
   a_sof_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req.start_of_frame |=> idx_ff == 4'd1)
      else $error("start mark did not restart the frame");

   // Byte 8 closes the frame and hands a record on.
   a_close: assert property (@(posedge clock) disable iff (reset)
      accept && !req.start_of_frame && idx_ff == FRAME_LAST |=>
         close_valid_ff && idx_ff == NO_FRAME)
      else $error("frame not closed on byte 8");

endmodule

`default_nettype wire

// File: design/spfd_decode.sv
// ----------------------------------------------------------------------------
// Soil probe frame decode stage
// Turns a frame record into status, temperature and battery values and
// holds them in the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfd_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              close_valid,
   input  wire spfd_pkg::close_type close,
   output logic                   close_ready,
   input  wire spfd_pkg::cfg_type cfg,
   spfd_rsp_if.source             rsp
);
   import spfd_pkg::*;

   logic               out_valid_ff, out_valid_in;
   status_type         status_ff, status_in;
   logic [23:0]        sensor_id_ff;
   logic signed [12:0] temp_ff, temp_in;
   logic [11:0]        battery_mv_ff, battery_mv_in;
   logic               battery_low_ff, battery_low_in;
   logic [7:0]         rssi_ff;

   logic signed [12:0] raw_tenths;
   logic [6:0]         battery_steps;
   logic               in_range;

   assign close_ready = !out_valid_ff || rsp.ready;

   // Temperature: 12-bit signed raw value, 40 degree offset unless subtype 4.
   always_comb begin
      raw_tenths = $signed({close.temp_hi_byte[3], close.temp_hi_byte[3:0],
                            close.temp_lo_byte});
      if (close.temp_hi_byte[7:4] == SUBTYPE_NO_OFFSET) begin
         temp_in = raw_tenths;
      end else begin
         temp_in = raw_tenths - OFFSET_TENTHS;
      end
      in_range = (temp_in >= $signed(cfg.min_temp_tenths)) &&
                 (temp_in <= $signed(cfg.max_temp_tenths));
   end

   // Battery: 20 mV steps, built as 16x plus 4x.
   always_comb begin
      battery_steps  = close.battery_byte[6:0];
      battery_mv_in  = {1'b0, battery_steps, 4'b0000} + {3'b000, battery_steps, 2'b00};
      battery_low_in = (battery_mv_in != 12'd0) && (battery_mv_in < cfg.low_battery_mv);
   end

   // First failing check wins.
   always_comb begin
      priority if (!close.family_ok) begin
         status_in = STATUS_FAMILY;
      end else if (!close.crc_ok) begin
         status_in = STATUS_CRC;
      end else if (!close.sum_ok) begin
         status_in = STATUS_SUM;
      end else if (!in_range) begin
         status_in = STATUS_RANGE;
      end else begin
         status_in = STATUS_OK;
      end
   end

   // Result valid follows the transfer on either side.
   always_comb begin
      if (close_ready) begin
         out_valid_in = close_valid;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (close_valid && close_ready) begin
         status_ff      <= status_in;
         sensor_id_ff   <= close.sensor_id;
         temp_ff        <= temp_in;
         battery_mv_ff  <= battery_mv_in;
         battery_low_ff <= battery_low_in;
         rssi_ff        <= close.rssi_dbm;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.sensor_id   = sensor_id_ff;
   assign rsp.temp_tenths = temp_ff;
   assign rsp.battery_mv  = battery_mv_ff;
   assign rsp.battery_low = battery_low_ff;
   assign rsp.rssi_dbm    = $signed(rssi_ff);

   // A passing result lies within the configured limits.
   a_ok_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && status_ff == STATUS_OK |->
         temp_ff >= $signed(cfg.min_temp_tenths) && temp_ff <= $signed(cfg.max_temp_tenths))
      else $error("ok status outside temperature limits");

   // Low battery needs a nonzero reading under the threshold.
   a_low_battery: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && battery_low_ff |->
         battery_mv_ff != 12'd0 && battery_mv_ff < cfg.low_battery_mv)
      else $error("low battery flag inconsistent");

   // A wrong family always reports as such, ahead of the other checks.
   a_family_first: assert property (@(posedge clock) disable iff (reset)
      close_valid && close_ready && !close.family_ok |=>
         out_valid_ff && status_ff == STATUS_FAMILY)
      else $error("family failure not reported");

endmodule

`default_nettype wire

// File: design/soil_probe_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// Soil probe frame decoder
// Decodes nine-byte sensor frames into id, temperature, battery and status.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle; a stalled result side holds the byte input
//   off once both the frame record and the result register are full.
// Result path: the transfer of byte 8 of a frame loads its frame record register, and
//   the record then moves on into the result register, where the result becomes valid.
// Reset: synchronous, active high; registers return to their defaults, no frame
//   is open and both pipeline stages are empty. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module soil_probe_frame_decoder_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   spfd_req_if.sink                                  req_chan,
   spfd_rsp_if.source                                rsp_chan,
   input  wire logic                                 csr_write_enable,
   input  wire logic [spfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [spfd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import spfd_pkg::*;

   cfg_type   cfg;
   close_type close;
   logic      close_valid;
   logic      close_ready;

   // Configuration registers.
   spfd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Byte tracking, CRC and sum.
   spfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .crc_init    (cfg.crc_init),
      .close_valid (close_valid),
      .close       (close),
      .close_ready (close_ready)
   );

   // Field decode and result register.
   spfd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .close_valid (close_valid),
      .close       (close),
      .close_ready (close_ready),
      .cfg         (cfg),
      .rsp         (rsp_chan)
   );

endmodule

`default_nettype wire

// File: verif/frame_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil probe frame decoder checker
// Watches the byte and result channels and the register port. It keeps its
// own copy of the frame state and settings, predicts the decoded reading for
// every closed frame, and compares each result transfer against the oldest
// prediction.
// ----------------------------------------------------------------------------

module frame_decode_checker
   import spfd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   spfd_req_if                        req_mon,
   spfd_rsp_if                        rsp_mon,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int unsigned                mismatch_count,
   output int unsigned                pending_readings,
   output int unsigned                results_checked,
   output int unsigned                faulted_results
);

   localparam logic [11:0] BATTERY_STEP_MV = 12'd20;

   // One decoded reading, as it should appear on the result channel.
   typedef struct packed {
      status_type         status;
      logic [23:0]        sensor_id;
      logic signed [12:0] temp_tenths;
      logic [11:0]        battery_mv;
      logic               battery_low;
      logic signed [7:0]  rssi_dbm;
   } reading_type;

   reading_type expected_readings[$];

   // Shadow copy of the settings.
   logic [7:0]         crc_seed;
   logic [11:0]        low_batt_limit;
   logic signed [12:0] temp_floor;
   logic signed [12:0] temp_ceiling;

   // Shadow copy of the open frame.
   logic [3:0]        byte_pos;
   logic [7:0]        crc_acc;
   logic [7:0]        sum_acc;
   logic              family_seen;
   logic [23:0]       id_acc;
   logic [7:0]        temp_hi;
   logic [7:0]        temp_lo;
   logic [7:0]        batt_raw;
   logic signed [7:0] rssi_capt;

   int unsigned mismatches = 0;
   int unsigned checked = 0;
   int unsigned faulted = 0;

   // Bit-serial CRC-8: feed the data MSB first through the feedback tap.
   function automatic logic [7:0] crc31_step(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] r;
      logic       fb;
      r = acc;
      for (int k = 7; k >= 0; k--) begin
         fb = r[7] ^ data[k];
         r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   // Decode the captured frame; the check byte is byte 8.
   function automatic reading_type close_frame(input logic [7:0] check_sum);
      reading_type        r;
      logic signed [12:0] raw;
      logic signed [12:0] temp;
      raw  = {temp_hi[3], temp_hi[3:0], temp_lo};
      temp = (temp_hi[7:4] == SUBTYPE_NO_OFFSET) ? raw : raw - OFFSET_TENTHS;
      r.sensor_id   = id_acc;
      r.temp_tenths = temp;
      r.battery_mv  = 12'(batt_raw[6:0]) * BATTERY_STEP_MV;
      r.battery_low = (r.battery_mv != 12'd0) && (r.battery_mv < low_batt_limit);
      r.rssi_dbm    = rssi_capt;
      // The first failing check wins.
      if (!family_seen) begin
         r.status = STATUS_FAMILY;
      end else if (crc_acc != 8'h00) begin
         r.status = STATUS_CRC;
      end else if (sum_acc != check_sum) begin
         r.status = STATUS_SUM;
      end else if (temp < temp_floor || temp > temp_ceiling) begin
         r.status = STATUS_RANGE;
      end else begin
         r.status = STATUS_OK;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] decode check: %s", $time, what);
   endtask

   // Follow one accepted frame byte through the frame state.
   task automatic track_byte(input logic [7:0] value, input logic opens,
                             input logic signed [7:0] dbm);
      if (opens) begin
         byte_pos  = 4'd0;
         crc_acc   = crc_seed;
         sum_acc   = 8'h00;
         rssi_capt = dbm;
      end
      if (byte_pos < FRAME_LAST) begin
         crc_acc = crc31_step(crc_acc, value);
         sum_acc = sum_acc + value;
         case (byte_pos)
            4'd0: family_seen = (value == FAMILY_CODE);
            4'd1: id_acc[23:16] = value;
            4'd2: id_acc[15:8] = value;
            4'd3: id_acc[7:0] = value;
            4'd4: temp_hi = value;
            4'd5: temp_lo = value;
            4'd6: batt_raw = value;
            default: ;
         endcase
         byte_pos = byte_pos + 4'd1;
      end else if (byte_pos == FRAME_LAST) begin
         byte_pos = NO_FRAME;
         expected_readings.push_back(close_frame(value));
      end
   endtask

   // Compare one result transfer with the oldest prediction.
   task automatic check_reading();
      reading_type want;
      string       diffs;
      checked++;
      if (rsp_mon.status != STATUS_OK) begin
         faulted++;
      end
      if (expected_readings.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with no frame outstanding (id %06h)",
                                   checked, rsp_mon.sensor_id));
         return;
      end
      want  = expected_readings.pop_front();
      diffs = "";
      if (rsp_mon.status !== want.status) begin
         diffs = {diffs, $sformatf(" status %0d/%0d", rsp_mon.status, want.status)};
      end
      if (rsp_mon.sensor_id !== want.sensor_id) begin
         diffs = {diffs, $sformatf(" sensor_id %06h/%06h", rsp_mon.sensor_id, want.sensor_id)};
      end
      if (rsp_mon.temp_tenths !== want.temp_tenths) begin
         diffs = {diffs, $sformatf(" temp_tenths %0d/%0d", rsp_mon.temp_tenths,
                                   $signed(want.temp_tenths))};
      end
      if (rsp_mon.battery_mv !== want.battery_mv) begin
         diffs = {diffs, $sformatf(" battery_mv %0d/%0d", rsp_mon.battery_mv, want.battery_mv)};
      end
      if (rsp_mon.battery_low !== want.battery_low) begin
         diffs = {diffs, $sformatf(" battery_low %0b/%0b", rsp_mon.battery_low,
                                   want.battery_low)};
      end
      if (rsp_mon.rssi_dbm !== want.rssi_dbm) begin
         diffs = {diffs, $sformatf(" rssi_dbm %0d/%0d", rsp_mon.rssi_dbm,
                                   $signed(want.rssi_dbm))};
      end
      if (diffs != "") begin
         report_mismatch($sformatf("result %0d, got/expected:%s", checked, diffs));
      end
   endtask

   // Sample everything on the rising edge; results are checked before a
   // byte of the same cycle can add a new prediction.
   always @(posedge clock) begin
      if (reset) begin
         crc_seed       = CRC_INIT_RESET;
         low_batt_limit = LOW_BATTERY_RESET;
         temp_floor     = MIN_TEMP_RESET;
         temp_ceiling   = MAX_TEMP_RESET;
         byte_pos       = NO_FRAME;
         crc_acc        = 8'h00;
         sum_acc        = 8'h00;
         family_seen    = 1'b0;
         id_acc         = 24'h000000;
         temp_hi        = 8'h00;
         temp_lo        = 8'h00;
         batt_raw       = 8'h00;
         rssi_capt      = 8'sd0;
         expected_readings.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            check_reading();
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            track_byte(req_mon.frame_byte, req_mon.start_of_frame, req_mon.signal_dbm);
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CRC_INIT:       crc_seed = csr_write_data[7:0];
               CSR_LOW_BATTERY_MV: low_batt_limit = csr_write_data[11:0];
               CSR_MIN_TEMP:       temp_floor = csr_write_data;
               CSR_MAX_TEMP:       temp_ceiling = csr_write_data;
               default: ;
            endcase
         end
      end
      mismatch_count   <= mismatches;
      pending_readings <= expected_readings.size();
      results_checked  <= checked;
      faulted_results  <= faulted;
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil probe frame decoder testbench
// Feeds frame bytes under several register settings: a few hand-picked
// frames first, then mostly well-formed random frames mixed with faulty,
// short, noisy and stray traffic. Both channels idle at random and the
// result side is once held off long enough to back the decoder up.
// ----------------------------------------------------------------------------

module tb_top;
   import spfd_pkg::*;

   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES    = 4;
   localparam int unsigned DRAIN_CYCLES     = 10;
   localparam int unsigned PHASE_ITEMS      = 160;

   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_FAMILY,
      FRAME_BAD_CRC,
      FRAME_BAD_SUM
   } frame_fault_type;

   logic clock = 1'b0;
   logic reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   int unsigned mismatch_count;
   int unsigned pending_readings;
   int unsigned results_checked;
   int unsigned faulted_results;

   logic [7:0]  crc_seed_now = CRC_INIT_RESET;
   bit          sender_burst = 1'b0;
   logic        long_hold_req = 1'b0;
   int unsigned frame_items = 0;
   int unsigned settings_applied = 0;

   spfd_req_if req_chan ();
   spfd_rsp_if rsp_chan ();

   always #4 clock = ~clock;

   soil_probe_frame_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   frame_decode_checker decode_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_readings (pending_readings),
      .results_checked  (results_checked),
      .faulted_results  (faulted_results)
   );

   // Mostly short gaps, a few long ones, none while in a burst.
   function automatic int unsigned idle_gap(input bit burst);
      int unsigned r;
      if (burst) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 20);
   endfunction

   function automatic logic signed [7:0] rand_dbm();
      return 8'(-int'($urandom_range(0, 128)));
   endfunction

   function automatic frame_fault_type pick_fault();
      case ($urandom_range(0, 11))
         0:       return FRAME_BAD_FAMILY;
         1:       return FRAME_BAD_CRC;
         2:       return FRAME_BAD_SUM;
         default: return FRAME_GOOD;
      endcase
   endfunction

   // Offer one byte and wait for its transfer; valid stays high afterwards.
   task automatic send_byte(input logic [7:0] value, input logic opens,
                            input logic signed [7:0] dbm);
      int unsigned gap;
      gap = idle_gap(sender_burst);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.frame_byte     <= value;
      req_chan.start_of_frame <= opens;
      req_chan.signal_dbm     <= dbm;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
   endtask

   // Build a frame with a valid CRC and sum, spoil one check if asked, and
   // send the first sent_len bytes followed by some ignored trailing bytes.
   task automatic send_frame(input logic [23:0] id, input logic [7:0] t_hi,
                             input logic [7:0] t_lo, input logic [7:0] batt,
                             input frame_fault_type fault, input logic signed [7:0] dbm,
                             input int unsigned sent_len, input int unsigned trailing);
      logic [7:0] frame_bytes [9];
      logic [7:0] crc_run;
      logic [7:0] sum_run;
      frame_bytes[0] = FAMILY_CODE;
      if (fault == FRAME_BAD_FAMILY) begin
         frame_bytes[0] = 8'($urandom_range(0, 255));
         if (frame_bytes[0] == FAMILY_CODE) begin
            frame_bytes[0] = ~FAMILY_CODE;
         end
      end
      frame_bytes[1] = id[23:16];
      frame_bytes[2] = id[15:8];
      frame_bytes[3] = id[7:0];
      frame_bytes[4] = t_hi;
      frame_bytes[5] = t_lo;
      frame_bytes[6] = batt;
      crc_run = crc_seed_now;
      for (int i = 0; i < 7; i++) begin
         crc_run = crc8_update(crc_run, frame_bytes[i]);
      end
      frame_bytes[7] = crc_run;
      if (fault == FRAME_BAD_CRC) begin
         frame_bytes[7] = crc_run ^ 8'($urandom_range(1, 255));
      end
      sum_run = 8'h00;
      for (int i = 0; i < 8; i++) begin
         sum_run = sum_run + frame_bytes[i];
      end
      frame_bytes[8] = sum_run;
      if (fault == FRAME_BAD_SUM) begin
         frame_bytes[8] = sum_run ^ 8'($urandom_range(1, 255));
      end
      // Only byte 0 carries the real signal strength; the rest is ignored.
      for (int i = 0; i < sent_len; i++) begin
         send_byte(frame_bytes[i], i == 0, (i == 0) ? dbm : rand_dbm());
      end
      frame_items += sent_len;
      repeat (trailing) send_byte(8'($urandom_range(0, 255)), 1'b0, rand_dbm());
   endtask

   task automatic send_random_frame(input frame_fault_type fault, input int unsigned sent_len,
                                    input int unsigned trailing);
      logic [7:0] t_hi;
      logic [7:0] batt;
      t_hi = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0) begin
         t_hi[7:4] = SUBTYPE_NO_OFFSET;
      end
      batt = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) begin
         batt[6:0] = 7'd0;
      end
      send_frame(24'($urandom), t_hi, 8'($urandom_range(0, 255)), batt, fault, rand_dbm(),
                 sent_len, trailing);
   endtask

   // Random traffic: mostly complete frames, then short, stray and noise.
   task automatic run_random(input int unsigned budget);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = frame_items + budget;
      while (frame_items < stop_at) begin
         sender_burst = ($urandom_range(0, 9) < 3);
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            send_random_frame(pick_fault(), 9,
                              ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
         end else if (pick < 84) begin
            send_random_frame(pick_fault(), $urandom_range(1, 8), 0);
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 3)) begin
               send_byte(8'($urandom_range(0, 255)), 1'b0, rand_dbm());
            end
         end else begin
            for (int i = 0; i < 9; i++) begin
               send_byte(8'($urandom_range(0, 255)), i == 0, rand_dbm());
            end
            frame_items += 9;
         end
      end
   endtask

   // Stop offering bytes and let every outstanding result drain.
   task automatic wait_until_idle(input int unsigned extra);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_readings != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type which,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= which;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [7:0] crc, input int unsigned low_mv,
                                input int lo, input int hi);
      wait_until_idle(SETTLE_CYCLES);
      write_register(CSR_CRC_INIT, 13'(crc));
      write_register(CSR_LOW_BATTERY_MV, 13'(low_mv));
      write_register(CSR_MIN_TEMP, 13'(lo));
      write_register(CSR_MAX_TEMP, 13'(hi));
      csr_write_enable <= 1'b0;
      crc_seed_now = crc;
      settings_applied++;
   endtask

   function automatic int rand_temp();
      return int'($urandom_range(0, 4495)) - 2448;
   endfunction

   // Result side: random stalls, occasional bursts, and one long hold-off.
   initial begin : result_receiver
      int unsigned stall;
      bit          long_hold_done;
      bit          rsp_burst;
      long_hold_done = 1'b0;
      rsp_burst      = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) begin
            rsp_burst = !rsp_burst;
         end
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall = LONG_HOLD_CYCLES;
         end else begin
            stall = idle_gap(rsp_burst);
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin : byte_source
      int lo;
      int hi;
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.frame_byte     <= 8'h00;
      req_chan.start_of_frame <= 1'b0;
      req_chan.signal_dbm     <= 8'sd0;
      csr_write_enable        <= 1'b0;
      csr_index               <= CSR_CRC_INIT;
      csr_write_data          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Hand-picked frames under the reset settings: a stray byte with no
      // frame open, a short frame cut off by the next start, extreme values
      // with no temperature offset plus a trailing byte, and the lowest
      // temperature with offset, no battery and a bad CRC.
      send_byte(8'hA5, 1'b0, rand_dbm());
      send_frame(24'h123456, 8'h41, 8'h00, 8'h10, FRAME_GOOD, -8'sd40, 2, 0);
      send_frame(24'hFFFFFF, 8'h47, 8'hFF, 8'h7F, FRAME_GOOD, -8'sd128, 9, 1);
      send_frame(24'h000000, 8'hF8, 8'h00, 8'h00, FRAME_BAD_CRC, 8'sd0, 9, 0);
      run_random(PHASE_ITEMS);

      // Widest temperature window, all-ones CRC seed, highest threshold.
      // The result side is held off here while bytes keep coming.
      apply_setting(8'hFF, 2540, -2448, 2047);
      long_hold_req <= 1'b1;
      sender_burst = 1'b1;
      repeat (8) send_random_frame(FRAME_GOOD, 9, 0);
      run_random(PHASE_ITEMS);

      // Inverted window and a zero threshold.
      apply_setting(8'h00, 0, 2047, -2448);
      run_random(PHASE_ITEMS);

      // Random ordered window.
      lo = rand_temp();
      hi = rand_temp();
      if (lo > hi) begin
         apply_setting(8'($urandom_range(0, 255)), 1200, hi, lo);
      end else begin
         apply_setting(8'($urandom_range(0, 255)), 1200, lo, hi);
      end
      run_random(PHASE_ITEMS);

      // Everything random.
      apply_setting(8'($urandom_range(0, 255)), $urandom_range(0, 2540), rand_temp(),
                    rand_temp());
      run_random(PHASE_ITEMS);

      wait_until_idle(DRAIN_CYCLES);
      $display("Covered %0d frame bytes over %0d register settings after reset defaults.",
               frame_items, settings_applied);
      $display("Checked %0d decoded results, %0d of them with a fault status.",
               results_checked, faulted_results);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog for a hung handshake or a result that never arrives.
   initial begin : watchdog
      #4000000;
      $display("Run timed out with %0d results outstanding.", pending_readings);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
design/spfd_pkg.sv
design/spfd_if.sv
design/spfd_csr.sv
design/spfd_frame.sv
design/spfd_decode.sv
design/soil_probe_frame_decoder_top.sv
verif/frame_decode_checker.sv
verif/tb_top.sv
